@@ hdl/mixed_fraction_alu_macros.svh @@
// Assertion macros for the mixed fraction ALU checker.
`ifndef MIXED_FRACTION_ALU_MACROS_SVH
`define MIXED_FRACTION_ALU_MACROS_SVH
// Assert an implication, checked outside reset.
`define MFA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%s failed", "label");
// Assert an implication in the next cycle, checked outside reset.
`define MFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%s failed", "label");
`endif

@@ hdl/mfa_pkg.sv @@
// Package: types and command codes for the mixed fraction ALU.
`default_nettype none
package mfa_pkg;
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_ADD = 2'd2,
    OP_SUB = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IMPROPER,
    ST_CROSS_A,
    ST_CROSS_B,
    ST_COMBINE,
    ST_CHECK,
    ST_WHOLE_DIV,
    ST_GCD_DIV,
    ST_NUM_DIV,
    ST_DEN_DIV,
    ST_DONE
  } state_t;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic load;
    logic improper;
    logic cross_a;
    logic cross_b;
    logic combine;
    logic div_start;
    logic [1:0] div_sel;
    logic take_whole;
    logic take_gcd_step;
    logic take_num;
    logic take_den;
    logic set_err;
    logic out_load;
  } cmd_t;

  // Status returned to the controller.
  typedef struct packed {
    logic in_zero_den;
    logic d_zero;
    logic n_gt_d;
    logic y_zero;
    logic g_zero;
    logic div_done;
  } stat_t;

  localparam logic [1:0] DSEL_WHOLE = 2'd0;
  localparam logic [1:0] DSEL_GCD = 2'd1;
  localparam logic [1:0] DSEL_NUM = 2'd2;
  localparam logic [1:0] DSEL_DEN = 2'd3;
endpackage
`default_nettype wire

@@ hdl/mfa_if.sv @@
// Valid/ready channel interfaces for the mixed fraction ALU.
`default_nettype none
interface mfa_in_if;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic signed [15:0] a_whole;
  logic signed [15:0] a_numerator;
  logic signed [15:0] a_denominator;
  logic signed [15:0] b_whole;
  logic signed [15:0] b_numerator;
  logic signed [15:0] b_denominator;
  modport source(output valid, req_type, a_whole, a_numerator, a_denominator,
                 b_whole, b_numerator, b_denominator, input ready);
  modport sink(input valid, req_type, a_whole, a_numerator, a_denominator,
               b_whole, b_numerator, b_denominator, output ready);
endinterface

interface mfa_out_if;
  logic valid;
  logic ready;
  logic signed [63:0] result_whole;
  logic signed [63:0] result_numerator;
  logic signed [63:0] result_denominator;
  logic zero_divide_error;
  modport source(output valid, result_whole, result_numerator, result_denominator,
                 zero_divide_error, input ready);
  modport sink(input valid, result_whole, result_numerator, result_denominator,
               zero_divide_error, output ready);
endinterface
`default_nettype wire

@@ hdl/mfa_divider.sv @@
// Serial signed 64-bit divider, one quotient bit per cycle, C truncation.
`default_nettype none
module mfa_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] dividend,
  input  wire logic signed [63:0] divisor,
  output logic                    done,
  output logic signed [63:0]      quotient,
  output logic signed [63:0]      remainder
);
  logic        busy;
  logic [6:0]  count;
  logic [63:0] rem_acc;
  logic [63:0] quo_acc;
  logic [63:0] dvs;
  logic        neg_q;
  logic        neg_r;
  logic [64:0] trial;
  logic [63:0] rem_shift;

  assign rem_shift = {rem_acc[62:0], quo_acc[63]};
  assign trial = {1'b0, rem_shift} - {1'b0, dvs};

  // Restoring division on magnitudes.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 7'd64;
      end else if (busy) begin
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_acc <= '0;
      quo_acc <= dividend[63] ? 64'(-dividend) : dividend;
      dvs <= divisor[63] ? 64'(-divisor) : divisor;
      neg_q <= dividend[63] ^ divisor[63];
      neg_r <= dividend[63];
    end else if (busy) begin
      if (!trial[64]) begin
        rem_acc <= trial[63:0];
        quo_acc <= {quo_acc[62:0], 1'b1};
      end else begin
        rem_acc <= rem_shift;
        quo_acc <= {quo_acc[62:0], 1'b0};
      end
    end
  end

  assign quotient = neg_q ? -$signed(quo_acc) : $signed(quo_acc);
  assign remainder = neg_r ? -$signed(rem_acc) : $signed(rem_acc);
endmodule
`default_nettype wire

@@ hdl/mfa_datapath.sv @@
// Datapath: operand registers, cross products, shared divider, output register.
`default_nettype none
module mfa_datapath #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire mfa_pkg::cmd_t cmd,
  output mfa_pkg::stat_t   stat,
  mfa_in_if.sink           in_ch,
  mfa_out_if.source        out_ch
);
  logic [1:0] op;
  logic signed [63:0] aw, an, ad, bw, bn, bd;
  logic signed [63:0] p0, p1;
  logic signed [63:0] n, d, w, x, y, g;
  logic signed [63:0] dvd, dvs, quo, rem;
  logic div_done;

  function automatic logic signed [63:0] sext(input logic [15:0] v);
    logic [OPERAND_WIDTH-1:0] t;
    t = v[OPERAND_WIDTH-1:0];
    return 64'($signed(t));
  endfunction

  // Signed 32 by 32 product; improper numerators stay below 2^31.
  function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p;
  endfunction

  // Select divider operands.
  always_comb begin
    unique case (cmd.div_sel)
      mfa_pkg::DSEL_WHOLE: begin dvd = n; dvs = d; end
      mfa_pkg::DSEL_GCD:   begin dvd = x; dvs = y; end
      mfa_pkg::DSEL_NUM:   begin dvd = n; dvs = g; end
      default:             begin dvd = d; dvs = g; end
    endcase
  end

  mfa_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(dvd), .divisor(dvs),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  // Sequence the arithmetic, at most two multiplies per step.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_ch.req_type;
      aw <= sext(in_ch.a_whole);
      an <= sext(in_ch.a_numerator);
      ad <= sext(in_ch.a_denominator);
      bw <= sext(in_ch.b_whole);
      bn <= sext(in_ch.b_numerator);
      bd <= sext(in_ch.b_denominator);
      w <= '0;
    end
    if (cmd.improper) begin
      an <= smul(aw[31:0], ad[31:0]) + an;
      bn <= smul(bw[31:0], bd[31:0]) + bn;
    end
    if (cmd.cross_a) begin
      p0 <= (op == mfa_pkg::OP_MUL) ? smul(an[31:0], bn[31:0]) : smul(an[31:0], bd[31:0]);
      p1 <= (op == mfa_pkg::OP_DIV) ? smul(ad[31:0], bn[31:0]) : smul(ad[31:0], bd[31:0]);
    end
    if (cmd.cross_b) begin
      n <= p0;
      d <= p1;
      if (op == mfa_pkg::OP_ADD || op == mfa_pkg::OP_SUB) p0 <= smul(ad[31:0], bn[31:0]);
    end
    if (cmd.combine) begin
      if (op == mfa_pkg::OP_ADD) n <= n + p0;
      else if (op == mfa_pkg::OP_SUB) n <= n - p0;
      x <= '0;
    end
    if (cmd.take_whole) begin
      w <= quo;
      n <= rem;
    end
    if (cmd.div_sel == mfa_pkg::DSEL_WHOLE && !cmd.take_whole && !cmd.div_start
        && !cmd.combine && cmd.take_gcd_step) begin
      x <= n;
      y <= d;
    end else if (cmd.take_gcd_step) begin
      x <= y;
      y <= rem;
    end
    if (cmd.take_num) n <= quo;
    if (cmd.take_den) d <= quo;
  end

  // Hold the gcd once the remainder reaches zero.
  assign g = x;

  assign stat.in_zero_den = (ad == 0) || (bd == 0);
  assign stat.d_zero = (p1 == 0);
  assign stat.n_gt_d = n > d;
  assign stat.y_zero = (y == 0);
  assign stat.g_zero = (x == 0);
  assign stat.div_done = div_done;

  // Output register; holds until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (cmd.out_load) out_ch.valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.zero_divide_error <= cmd.set_err;
      out_ch.result_whole <= cmd.set_err ? '0 : w;
      out_ch.result_numerator <= cmd.set_err ? '0 : n;
      out_ch.result_denominator <= cmd.set_err ? '0 : d;
    end
  end
endmodule
`default_nettype wire

@@ hdl/mfa_ctrl.sv @@
// Controller state machine for the mixed fraction ALU.
`default_nettype none
module mfa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          out_busy,
  input  wire mfa_pkg::stat_t stat,
  output mfa_pkg::cmd_t      cmd
);
  mfa_pkg::state_t state, state_next;
  logic err, err_next;
  logic div_run, div_run_next;
  logic whole_done, whole_done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfa_pkg::ST_IDLE;
      err <= 1'b0;
      div_run <= 1'b0;
      whole_done <= 1'b0;
    end else begin
      state <= state_next;
      err <= err_next;
      div_run <= div_run_next;
      whole_done <= whole_done_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    err_next = err;
    div_run_next = div_run;
    whole_done_next = whole_done;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      mfa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          err_next = 1'b0;
          whole_done_next = 1'b0;
          state_next = mfa_pkg::ST_IMPROPER;
        end
      end
      mfa_pkg::ST_IMPROPER: begin
        if (stat.in_zero_den) begin
          err_next = 1'b1;
          state_next = mfa_pkg::ST_DONE;
        end else begin
          cmd.improper = 1'b1;
          state_next = mfa_pkg::ST_CROSS_A;
        end
      end
      mfa_pkg::ST_CROSS_A: begin
        cmd.cross_a = 1'b1;
        state_next = mfa_pkg::ST_CROSS_B;
      end
      mfa_pkg::ST_CROSS_B: begin
        cmd.cross_b = 1'b1;
        if (stat.d_zero) begin
          err_next = 1'b1;
          state_next = mfa_pkg::ST_DONE;
        end else state_next = mfa_pkg::ST_COMBINE;
      end
      mfa_pkg::ST_COMBINE: begin
        cmd.combine = 1'b1;
        state_next = mfa_pkg::ST_CHECK;
      end
      mfa_pkg::ST_CHECK: begin
        // Split off the whole part at most once.
        cmd.div_sel = mfa_pkg::DSEL_WHOLE;
        if (stat.n_gt_d && !whole_done) begin
          cmd.div_start = 1'b1;
          div_run_next = 1'b1;
          state_next = mfa_pkg::ST_WHOLE_DIV;
        end else begin
          cmd.take_gcd_step = 1'b1;
          div_run_next = 1'b0;
          state_next = mfa_pkg::ST_GCD_DIV;
        end
      end
      mfa_pkg::ST_WHOLE_DIV: begin
        cmd.div_sel = mfa_pkg::DSEL_WHOLE;
        if (stat.div_done) begin
          cmd.take_whole = 1'b1;
          div_run_next = 1'b0;
          whole_done_next = 1'b1;
          state_next = mfa_pkg::ST_CHECK;
        end
      end
      mfa_pkg::ST_GCD_DIV: begin
        cmd.div_sel = mfa_pkg::DSEL_GCD;
        if (!div_run) begin
          if (stat.y_zero) begin
            if (stat.g_zero) state_next = mfa_pkg::ST_DONE;
            else begin
              cmd.div_sel = mfa_pkg::DSEL_NUM;
              cmd.div_start = 1'b1;
              div_run_next = 1'b1;
              state_next = mfa_pkg::ST_NUM_DIV;
            end
          end else begin
            cmd.div_start = 1'b1;
            div_run_next = 1'b1;
          end
        end else if (stat.div_done) begin
          cmd.take_gcd_step = 1'b1;
          div_run_next = 1'b0;
        end
      end
      mfa_pkg::ST_NUM_DIV: begin
        cmd.div_sel = mfa_pkg::DSEL_NUM;
        if (stat.div_done) begin
          cmd.take_num = 1'b1;
          cmd.div_sel = mfa_pkg::DSEL_DEN;
          cmd.div_start = 1'b1;
          state_next = mfa_pkg::ST_DEN_DIV;
        end
      end
      mfa_pkg::ST_DEN_DIV: begin
        cmd.div_sel = mfa_pkg::DSEL_DEN;
        if (stat.div_done) begin
          cmd.take_den = 1'b1;
          div_run_next = 1'b0;
          state_next = mfa_pkg::ST_DONE;
        end
      end
      mfa_pkg::ST_DONE: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          cmd.set_err = err;
          state_next = mfa_pkg::ST_IDLE;
        end
      end
      default: state_next = mfa_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/mixed_fraction_alu.sv @@
// Top level of the mixed fraction ALU.
// Usage:
//   in_ch carries one request: req_type and two mixed fractions (whole,
//   numerator, denominator). An item is accepted when valid and ready are high.
//   out_ch returns one result item per request: whole, numerator, denominator
//   of the reduced result and zero_divide_error.
// Sequence: setup steps, then 64-bit serial divisions in the shared
//   restoring divider, one quotient bit a cycle. A request takes the
//   optional whole-part division, one division per Euclid step and two
//   final divisions.
//   An error item skips the divisions and goes straight to the output.
// Throughput: one request at a time; the next is taken once the result has
//   moved into the output register, which holds while the receiver stalls.
// Reset: synchronous rst returns the controller to idle and drops out valid.
`default_nettype none
module mixed_fraction_alu #(
  parameter int OPERAND_WIDTH = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  mfa_in_if.sink    in_ch,
  mfa_out_if.source out_ch
);
  mfa_pkg::cmd_t  cmd;
  mfa_pkg::stat_t stat;
  logic in_ready;

  assign in_ch.ready = in_ready;

  mfa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ready),
    .out_busy(out_ch.valid && !out_ch.ready), .stat(stat), .cmd(cmd)
  );

  mfa_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_ch(in_ch), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

@@ hdl/mfa_checker.sv @@
// Port-level checker for the mixed fraction ALU, with its bind.
`default_nettype none
`include "mixed_fraction_alu_macros.svh"
module mfa_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic err,
  input wire logic [63:0] rden
);
  `MFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `MFA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `MFA_ASSERT_IMP(a_err_zero, out_valid && err, rden == 64'd0)
  `MFA_ASSERT_NEXT(a_no_out_on_accept, in_valid && in_ready, !$rose(out_valid))
endmodule

bind mixed_fraction_alu mfa_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .err(out_ch.zero_divide_error), .rden(out_ch.result_denominator)
);
`default_nettype wire
